// File: rtl/core/eigenvectors_2x2_macros.svh
// Assertion macros shared by the eigenvector block.
`ifndef EIGENVECTORS_2X2_MACROS_SVH
`define EIGENVECTORS_2X2_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/core/eig2_pkg.sv
// Shared codes for the 2x2 eigenvector block.
package eig2_pkg;
  localparam logic [1:0] CASE_GENERAL = 2'd0;
  localparam logic [1:0] CASE_TRIANG  = 2'd1;
  localparam logic [1:0] CASE_DEGEN   = 2'd2;
endpackage

// File: rtl/core/eig_matrix_if.sv
// Request channel carrying one 2x2 matrix.
interface eig_matrix_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] entry_a;
  logic signed [WORD_BITS-1:0] entry_b;
  logic signed [WORD_BITS-1:0] entry_c;
  logic signed [WORD_BITS-1:0] entry_d;
  modport source (output valid, entry_a, entry_b, entry_c, entry_d, input ready);
  modport sink (input valid, entry_a, entry_b, entry_c, entry_d, output ready);
endinterface

// File: rtl/core/eig_vectors_if.sv
// Result channel carrying the two eigenvectors and status flags.
interface eig_vectors_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] first_top;
  logic signed [WORD_BITS-1:0] first_bottom;
  logic signed [WORD_BITS-1:0] second_top;
  logic signed [WORD_BITS-1:0] second_bottom;
  logic [1:0]                  case_taken;
  logic                        complex_flag;
  logic                        saturated_flag;
  modport source (output valid, first_top, first_bottom, second_top, second_bottom,
                  case_taken, complex_flag, saturated_flag, input ready);
  modport sink (input valid, first_top, first_bottom, second_top, second_bottom,
                case_taken, complex_flag, saturated_flag, output ready);
endinterface

// File: rtl/core/eigenvectors_2x2.sv
// Closed-form eigenvectors of a 2x2 matrix: the block takes one matrix request on
// the matrix channel (entries a, b, c, d, signed fixed point with FRAC_BITS
// fraction bits) and returns both eigenvectors as columns on the vectors channel,
// with the case taken, a complex flag for a negative discriminant (its root is
// taken as zero) and a flag for any component clipped to the word range.
// Both channels use valid/ready; a request moves when both are high.
// In order, three stages form D = d - a, the products and the discriminant,
// WORD_BITS + 1 stages take the square root one bit each, one stage forms the
// numerators, WORD_BITS + 2 + FRAC_BITS stages run the two dividers one quotient
// bit each, and the last stage saturates and holds the result.
// Throughput is one matrix per cycle while the receiver does not stall.
// Reset clears the valid bits of every stage; data registers are not reset.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// matrix.ready drops, so nothing is lost or repeated; bubbles move only while
// the output register is free or being drained.
`include "eigenvectors_2x2_macros.svh"
module eigenvectors_2x2
  import eig2_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  eig_matrix_if.sink    matrix,
  eig_vectors_if.source vectors
);
  localparam int W   = WORD_BITS;
  localparam int RW  = W + 1;          // root width
  localparam int DSW = 2 * RW;         // discriminant width
  localparam int RMW = RW + 2;         // root remainder width
  localparam int NW  = W + 2;          // numerator magnitude width
  localparam int NQ  = NW + FRAC_BITS; // shifted numerator and quotient width
  localparam int DW  = W + 1;          // denominator width
  localparam int NST = 5 + RW + NQ;    // pipeline depth
  localparam bit ONE_SAT = (FRAC_BITS >= W - 1);
  localparam logic [W-1:0] ONE_VAL = ONE_SAT ? ((W'(1) << (W - 1)) - W'(1))
                                             : (W'(1) << FRAC_BITS);
  localparam logic [NQ-1:0] LIM_POS = (NQ'(1) << (W - 1)) - NQ'(1);
  localparam logic [NQ-1:0] LIM_NEG = NQ'(1) << (W - 1);

  typedef struct packed {
    logic [1:0]          cs;
    logic signed [W:0]   dm;
    logic [W-1:0]        dmag;
    logic                bneg;
    logic [W-1:0]        bmag;
    logic                cneg;
    logic [W-1:0]        cmag;
  } ctx_t;

  typedef struct packed {
    ctx_t                ctx;
    logic                cplx;
    logic [DSW-1:0]      disc;
    logic [RMW-1:0]      rem;
    logic [RW-1:0]       root;
  } sqrt_t;

  typedef struct packed {
    logic [1:0]          cs;
    logic                cplx;
    logic                s1;
    logic                s2;
    logic [DW-1:0]       den;
    logic [NQ-1:0]       n1;
    logic [NQ-1:0]       n2;
    logic [DW-1:0]       r1;
    logic [DW-1:0]       r2;
    logic [NQ-1:0]       q1;
    logic [NQ-1:0]       q2;
  } div_t;

  logic [NST-1:0] vld;
  logic           adv;

  ctx_t           ctx1;
  ctx_t           ctx2;
  logic [2*W-1:0] sq2;
  logic [2*W-1:0] bc2;
  sqrt_t          sqs [RW+1];
  div_t           dvs [NQ+1];

  logic signed [W-1:0] ft;
  logic signed [W-1:0] fb;
  logic signed [W-1:0] st;
  logic signed [W-1:0] sb;
  logic [1:0]          cs_out;
  logic                cplx_out;
  logic                sat_out;

  assign adv          = !vld[NST-1] || vectors.ready;
  assign matrix.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], matrix.valid};
    end
  end

  // Stage 1: difference, magnitudes and case.
  always_ff @(posedge clk) begin
    logic signed [W:0] dmv;
    logic signed [W:0] bx;
    logic signed [W:0] cx;
    if (adv) begin
      dmv = {matrix.entry_d[W-1], matrix.entry_d} - {matrix.entry_a[W-1], matrix.entry_a};
      bx  = {matrix.entry_b[W-1], matrix.entry_b};
      cx  = {matrix.entry_c[W-1], matrix.entry_c};
      ctx1.dm   <= dmv;
      ctx1.dmag <= dmv[W] ? W'(-dmv) : W'(dmv);
      ctx1.bneg <= bx[W];
      ctx1.bmag <= bx[W] ? W'(-bx) : W'(bx);
      ctx1.cneg <= cx[W];
      ctx1.cmag <= cx[W] ? W'(-cx) : W'(cx);
      if (matrix.entry_c != '0) begin
        ctx1.cs <= CASE_GENERAL;
      end else if (dmv != '0) begin
        ctx1.cs <= CASE_TRIANG;
      end else begin
        ctx1.cs <= CASE_DEGEN;
      end
    end
  end

  // Stage 2: the two products.
  always_ff @(posedge clk) begin
    if (adv) begin
      ctx2 <= ctx1;
      sq2  <= ctx1.dmag * ctx1.dmag;
      bc2  <= ctx1.bmag * ctx1.cmag;
    end
  end

  // Stage 3: discriminant D^2 + 4bc, clamped at zero.
  always_ff @(posedge clk) begin
    logic [DSW-1:0] sqx;
    logic [DSW-1:0] bc4;
    logic           neg_bc;
    if (adv) begin
      sqx    = DSW'(sq2);
      bc4    = {bc2, 2'b00};
      neg_bc = ctx2.bneg != ctx2.cneg;
      sqs[0].ctx  <= ctx2;
      sqs[0].rem  <= '0;
      sqs[0].root <= '0;
      if (!neg_bc) begin
        sqs[0].disc <= sqx + bc4;
        sqs[0].cplx <= 1'b0;
      end else if (sqx >= bc4) begin
        sqs[0].disc <= sqx - bc4;
        sqs[0].cplx <= 1'b0;
      end else begin
        sqs[0].disc <= '0;
        sqs[0].cplx <= (ctx2.cs == CASE_GENERAL);
      end
    end
  end

  // Square root, one result bit per stage.
  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    always_ff @(posedge clk) begin
      logic [RMW-1:0] trem;
      logic [RMW-1:0] trial;
      if (adv) begin
        trem  = {sqs[i].rem[RMW-3:0], sqs[i].disc[DSW-1:DSW-2]};
        trial = {sqs[i].root, 2'b01};
        sqs[i+1].ctx  <= sqs[i].ctx;
        sqs[i+1].cplx <= sqs[i].cplx;
        sqs[i+1].disc <= {sqs[i].disc[DSW-3:0], 2'b00};
        if (trem >= trial) begin
          sqs[i+1].rem  <= trem - trial;
          sqs[i+1].root <= {sqs[i].root[RW-2:0], 1'b1};
        end else begin
          sqs[i+1].rem  <= trem;
          sqs[i+1].root <= {sqs[i].root[RW-2:0], 1'b0};
        end
      end
    end
  end

  // Numerators, signs and denominator for the two dividers.
  always_ff @(posedge clk) begin
    logic signed [W+2:0] rx;
    logic signed [W+2:0] dmx;
    logic signed [W+2:0] n1;
    logic signed [W+2:0] n2;
    ctx_t                cx;
    if (adv) begin
      cx  = sqs[RW].ctx;
      rx  = $signed({2'b00, sqs[RW].root});
      dmx = (W+3)'(cx.dm);
      n1  = -(dmx + rx);
      n2  = rx - dmx;
      dvs[0].cs   <= cx.cs;
      dvs[0].cplx <= sqs[RW].cplx;
      dvs[0].r1   <= '0;
      dvs[0].r2   <= '0;
      dvs[0].q1   <= '0;
      dvs[0].q2   <= '0;
      case (cx.cs)
        CASE_GENERAL: begin
          dvs[0].s1  <= n1[W+2] != cx.cneg;
          dvs[0].s2  <= n2[W+2] != cx.cneg;
          dvs[0].n1  <= {(n1[W+2] ? NW'(-n1) : NW'(n1)), {FRAC_BITS{1'b0}}};
          dvs[0].n2  <= {(n2[W+2] ? NW'(-n2) : NW'(n2)), {FRAC_BITS{1'b0}}};
          dvs[0].den <= {cx.cmag, 1'b0};
        end
        CASE_TRIANG: begin
          dvs[0].s1  <= 1'b0;
          dvs[0].s2  <= cx.bneg != cx.dm[W];
          dvs[0].n1  <= '0;
          dvs[0].n2  <= {NW'(cx.bmag), {FRAC_BITS{1'b0}}};
          dvs[0].den <= DW'(cx.dmag);
        end
        default: begin
          dvs[0].s1  <= 1'b0;
          dvs[0].s2  <= 1'b0;
          dvs[0].n1  <= '0;
          dvs[0].n2  <= '0;
          dvs[0].den <= DW'(1);
        end
      endcase
    end
  end

  // Two restoring dividers, one quotient bit per stage.
  for (genvar i = 0; i < NQ; i++) begin : g_div
    always_ff @(posedge clk) begin
      logic [DW:0] t1;
      logic [DW:0] t2;
      if (adv) begin
        t1 = {dvs[i].r1, dvs[i].n1[NQ-1]};
        t2 = {dvs[i].r2, dvs[i].n2[NQ-1]};
        dvs[i+1].cs   <= dvs[i].cs;
        dvs[i+1].cplx <= dvs[i].cplx;
        dvs[i+1].s1   <= dvs[i].s1;
        dvs[i+1].s2   <= dvs[i].s2;
        dvs[i+1].den  <= dvs[i].den;
        dvs[i+1].n1   <= {dvs[i].n1[NQ-2:0], 1'b0};
        dvs[i+1].n2   <= {dvs[i].n2[NQ-2:0], 1'b0};
        if (t1 >= {1'b0, dvs[i].den}) begin
          dvs[i+1].r1 <= DW'(t1 - {1'b0, dvs[i].den});
          dvs[i+1].q1 <= {dvs[i].q1[NQ-2:0], 1'b1};
        end else begin
          dvs[i+1].r1 <= DW'(t1);
          dvs[i+1].q1 <= {dvs[i].q1[NQ-2:0], 1'b0};
        end
        if (t2 >= {1'b0, dvs[i].den}) begin
          dvs[i+1].r2 <= DW'(t2 - {1'b0, dvs[i].den});
          dvs[i+1].q2 <= {dvs[i].q2[NQ-2:0], 1'b1};
        end else begin
          dvs[i+1].r2 <= DW'(t2);
          dvs[i+1].q2 <= {dvs[i].q2[NQ-2:0], 1'b0};
        end
      end
    end
  end

  // Returns {clipped, word} for a signed quotient magnitude.
  function automatic logic [W:0] sat_word(input logic neg, input logic [NQ-1:0] q);
    logic [NQ-1:0] lim;
    logic [W-1:0]  v;
    logic          clip;
    lim  = neg ? LIM_NEG : LIM_POS;
    clip = q > lim;
    v    = clip ? lim[W-1:0] : q[W-1:0];
    return {clip, (neg ? -v : v)};
  endfunction

  // Output stage: saturation and case selection.
  always_ff @(posedge clk) begin
    logic [W:0] w1;
    logic [W:0] w2;
    if (adv) begin
      w1 = sat_word(dvs[NQ].s1, dvs[NQ].q1);
      w2 = sat_word(dvs[NQ].s2, dvs[NQ].q2);
      cs_out   <= dvs[NQ].cs;
      cplx_out <= dvs[NQ].cplx;
      case (dvs[NQ].cs)
        CASE_GENERAL: begin
          ft      <= w1[W-1:0];
          fb      <= ONE_VAL;
          st      <= w2[W-1:0];
          sb      <= ONE_VAL;
          sat_out <= w1[W] | w2[W] | ONE_SAT;
        end
        CASE_TRIANG: begin
          ft      <= ONE_VAL;
          fb      <= '0;
          st      <= w2[W-1:0];
          sb      <= ONE_VAL;
          sat_out <= w2[W] | ONE_SAT;
        end
        default: begin
          ft      <= ONE_VAL;
          fb      <= '0;
          st      <= '0;
          sb      <= '0;
          sat_out <= ONE_SAT;
        end
      endcase
    end
  end

  assign vectors.valid          = vld[NST-1];
  assign vectors.first_top      = ft;
  assign vectors.first_bottom   = fb;
  assign vectors.second_top     = st;
  assign vectors.second_bottom  = sb;
  assign vectors.case_taken     = cs_out;
  assign vectors.complex_flag   = cplx_out;
  assign vectors.saturated_flag = sat_out;

  `ASSERT_IMPL(a_degen_zero, vectors.valid && vectors.case_taken == CASE_DEGEN, vectors.second_top == '0 && vectors.second_bottom == '0)
  `ASSERT_IMPL(a_cplx_general, vectors.valid && vectors.case_taken != CASE_GENERAL, !vectors.complex_flag)
  `ASSERT_NEXT(a_stall_hold, !adv, $stable(vld))
endmodule

// File: tb/sv/eigenvectors_2x2_checker.sv
// Checker that predicts the eigenvectors of each accepted matrix and compares results.
module eigenvectors_2x2_checker
  import eig2_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  eig_matrix_if.sink  matrix_mon,
  eig_vectors_if.sink vectors_mon,
  output int   fail_count,
  output int   pending_count,
  output int   result_count,
  output int   complex_count,
  output int   sat_count
);

  typedef struct packed {
    logic signed [WORD_BITS-1:0] first_top;
    logic signed [WORD_BITS-1:0] first_bottom;
    logic signed [WORD_BITS-1:0] second_top;
    logic signed [WORD_BITS-1:0] second_bottom;
    logic [1:0]                  case_taken;
    logic                        complex_flag;
    logic                        saturated_flag;
  } eigvec_t;

  eigvec_t expected_vectors[$];

  // Clips a sign/magnitude quotient to the word range.
  function automatic logic [WORD_BITS-1:0] clip_word(input logic neg,
                                                     input logic [255:0] mag,
                                                     inout logic sat);
    logic [255:0] lim;
    logic [255:0] v;
    lim = neg ? (256'd1 << (WORD_BITS - 1)) : (256'd1 << (WORD_BITS - 1)) - 1;
    v = mag;
    if (v > lim) begin
      v = lim;
      sat = 1'b1;
    end
    if (neg) v = -v;
    return v[WORD_BITS-1:0];
  endfunction

  function automatic logic [WORD_BITS-1:0] fixed_quotient(input logic signed [255:0] num,
                                                          input logic den_neg,
                                                          input logic [255:0] den_mag,
                                                          inout logic sat);
    logic [255:0] nmag;
    nmag = num < 0 ? -num : num;
    return clip_word((num < 0) != den_neg, (nmag << FRAC_BITS) / den_mag, sat);
  endfunction

  function automatic logic [255:0] floor_sqrt(input logic [255:0] v);
    logic [255:0] r;
    logic [255:0] t;
    r = 0;
    for (int bitpos = 127; bitpos >= 0; bitpos--) begin
      t = r | (256'd1 << bitpos);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic eigvec_t predict_vectors(input logic signed [WORD_BITS-1:0] a,
                                              input logic signed [WORD_BITS-1:0] b,
                                              input logic signed [WORD_BITS-1:0] c,
                                              input logic signed [WORD_BITS-1:0] d);
    eigvec_t e;
    logic signed [255:0] dm;
    logic signed [255:0] disc;
    logic signed [255:0] root;
    logic [255:0] cmag;
    logic sat;
    logic [WORD_BITS-1:0] one;
    sat = 1'b0;
    dm = 256'(signed'(d)) - 256'(signed'(a));
    one = clip_word(1'b0, 256'd1 << FRAC_BITS, sat);
    e = '0;
    if (c != 0) begin
      disc = dm * dm + 4 * 256'(signed'(b)) * 256'(signed'(c));
      if (disc < 0) begin
        disc = 0;
        e.complex_flag = 1'b1;
      end
      root = floor_sqrt(disc);
      cmag = c < 0 ? -256'(signed'(c)) : 256'(signed'(c));
      e.first_top = fixed_quotient(-(dm + root), c < 0, 2 * cmag, sat);
      e.second_top = fixed_quotient(root - dm, c < 0, 2 * cmag, sat);
      e.first_bottom = one;
      e.second_bottom = one;
      e.case_taken = CASE_GENERAL;
    end else if (dm != 0) begin
      e.first_top = one;
      e.second_top = fixed_quotient(256'(signed'(b)), dm < 0, dm < 0 ? -dm : dm, sat);
      e.second_bottom = one;
      e.case_taken = CASE_TRIANG;
    end else begin
      e.first_top = one;
      e.case_taken = CASE_DEGEN;
    end
    e.saturated_flag = sat;
    return e;
  endfunction

  assign pending_count = expected_vectors.size();

  always @(posedge clk) begin
    eigvec_t got;
    eigvec_t want;
    if (rst) begin
      fail_count <= 0;
      result_count <= 0;
      complex_count <= 0;
      sat_count <= 0;
    end else begin
      if (matrix_mon.valid && matrix_mon.ready)
        expected_vectors.push_back(predict_vectors(matrix_mon.entry_a, matrix_mon.entry_b,
                                                   matrix_mon.entry_c, matrix_mon.entry_d));
      if (vectors_mon.valid && vectors_mon.ready) begin
        got = '{vectors_mon.first_top, vectors_mon.first_bottom, vectors_mon.second_top,
                vectors_mon.second_bottom, vectors_mon.case_taken, vectors_mon.complex_flag,
                vectors_mon.saturated_flag};
        result_count <= result_count + 1;
        if (expected_vectors.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_vectors.pop_front();
          complex_count <= complex_count + want.complex_flag;
          sat_count <= sat_count + want.saturated_flag;
          if (got !== want) begin
            $display("%0t: mismatch expected ft=%h fb=%h st=%h sb=%h case=%0d cx=%b sat=%b",
                     $time, want.first_top, want.first_bottom, want.second_top,
                     want.second_bottom, want.case_taken, want.complex_flag,
                     want.saturated_flag);
            $display("%0t:          actual   ft=%h fb=%h st=%h sb=%h case=%0d cx=%b sat=%b",
                     $time, got.first_top, got.first_bottom, got.second_top,
                     got.second_bottom, got.case_taken, got.complex_flag, got.saturated_flag);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/sv/eigenvectors_2x2_test.sv
// Top of the eigenvector testbench: clock, reset, matrix stimulus and verdict.
module eigenvectors_2x2_test;
  import eig2_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int LATENCY = 2 * WORD_BITS + FRAC_BITS + 8;
  localparam int IDLE_LIMIT = 40 * LATENCY + 2000;
  localparam int RANDOM_COUNT = 1250;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_count;
  int   result_count;
  int   complex_count;
  int   sat_count;
  int   idle_cycles;
  int   stall_phase;

  eig_matrix_if  #(WORD_BITS) matrix ();
  eig_vectors_if #(WORD_BITS) vectors ();

  eigenvectors_2x2 #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) dut (
    .clk(clk), .rst(rst), .matrix(matrix), .vectors(vectors)
  );

  eigenvectors_2x2_checker #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) eig_check (
    .clk(clk), .rst(rst), .matrix_mon(matrix), .vectors_mon(vectors),
    .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count),
    .complex_count(complex_count), .sat_count(sat_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver alternates between open stretches and bursty stalls.
  always @(posedge clk) begin
    if (rst) begin
      vectors.ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= (stall_phase + 1) % 400;
      if (stall_phase < 100) vectors.ready <= 1'b1;
      else if (stall_phase < 250) vectors.ready <= ($urandom_range(0, 3) != 0);
      else vectors.ready <= ($urandom_range(0, 9) < 3);
    end
  end

  always @(posedge clk) begin
    if (rst || (matrix.valid && matrix.ready) || (vectors.valid && vectors.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d results pending", $time, pending_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [WORD_BITS-1:0] random_entry();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(signed'($urandom_range(0, 8)) - 4) <<< FRAC_BITS;
      3: return $urandom;
      4: return 32'($urandom_range(0, 65535)) - 32'd32768;
      default: return 32'(signed'($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  task automatic send_matrix(input logic [WORD_BITS-1:0] a, input logic [WORD_BITS-1:0] b,
                             input logic [WORD_BITS-1:0] c, input logic [WORD_BITS-1:0] d);
    matrix.valid <= 1'b1;
    matrix.entry_a <= a;
    matrix.entry_b <= b;
    matrix.entry_c <= c;
    matrix.entry_d <= d;
    @(posedge clk);
    while (!matrix.ready) @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    matrix.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
    logic [WORD_BITS-1:0] c;
    logic [WORD_BITS-1:0] d;
    int burst;
    int sent;
    rst = 1'b1;
    matrix.valid = 1'b0;
    matrix.entry_a = '0;
    matrix.entry_b = '0;
    matrix.entry_c = '0;
    matrix.entry_d = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: the three cases, complex and saturating requests, field extremes.
    send_matrix(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000);
    send_matrix(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000);
    send_matrix(32'h0001_0000, 32'h0001_0000, 32'hffff_0000, 32'h0001_0000);
    send_matrix(32'h0001_0000, 32'h0005_0000, 32'h0000_0000, 32'h0003_0000);
    send_matrix(32'h0003_0000, 32'h0005_0000, 32'h0000_0000, 32'h0001_0000);
    send_matrix(32'h0001_0000, 32'h0007_0000, 32'h0000_0000, 32'h0001_0000);
    send_matrix(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'h7fff_ffff);
    send_matrix(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000);
    send_matrix(32'h0000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'h0000_0001);
    send_matrix(32'h0000_0001, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    send_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_matrix(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_matrix(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_matrix(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_matrix(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_matrix(32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000);

    // Wait until every directed result has come back.
    pause_sender(1);
    while (pending_count != 0) @(posedge clk);

    sent = 0;
    while (sent < RANDOM_COUNT) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < RANDOM_COUNT; i++) begin
        a = random_entry();
        b = random_entry();
        c = ($urandom_range(0, 4) == 0) ? '0 : random_entry();
        d = ($urandom_range(0, 5) == 0) ? a : random_entry();
        send_matrix(a, b, c, d);
        sent++;
      end
      if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 12));
      else if ($urandom_range(0, 3) == 0) pause_sender(1);
    end
    matrix.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("Checked %0d eigenvector results (%0d complex, %0d saturated).",
             result_count, complex_count, sat_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/eig2_pkg.sv
rtl/core/eig_matrix_if.sv
rtl/core/eig_vectors_if.sv
rtl/core/eigenvectors_2x2.sv
tb/sv/eigenvectors_2x2_checker.sv
tb/sv/eigenvectors_2x2_test.sv
